// ----- design/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int WIN_LEN   = 25;
  localparam int BYTE_W    = 8;
  localparam int NUM_CH    = 16;
  localparam int CH_W      = 11;
  localparam int CHIDX_W   = 4;
  localparam int NORM_W    = 16;
  localparam int FRAC_W    = 12;
  // channel data bytes 1..22 of the window
  localparam int FRAME_BYTES = 22;
  localparam int FRAME_W   = FRAME_BYTES * BYTE_W;
  // divider: dividend is |raw - min| << 12
  localparam int DVD_W     = CH_W + FRAC_W;
  localparam int DCNT_W    = 5;
  localparam int CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0]    HEAD_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0]    TAIL_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0]    WIN_RESET = 8'hFF;
  localparam logic [CH_W-1:0]      MIN_RESET = 11'd172;
  localparam logic [CH_W-1:0]      MAX_RESET = 11'd1811;
  localparam logic [CHIDX_W-1:0]   LAST_CH   = 4'd15;
  localparam logic [DCNT_W-1:0]    DIV_LAST_STEP = 5'(DVD_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_MAX = 8'd1;

  localparam logic [NORM_W-1:0] NORM_POS_SAT = 16'h7FFF;
  localparam logic [NORM_W-1:0] NORM_NEG_SAT = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/sfd_window.sv -----
// ----------------------------------------------------------------------------
// sfd_window
// 25-byte receive shift line with frame delimiter detection.
// ----------------------------------------------------------------------------
module sfd_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift_en,
  input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          frame_match,
  output logic [sfd_pkg::FRAME_W-1:0]   frame_bits
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] win [WIN_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_LEN; i++) win[i] <= WIN_RESET;
    end else if (shift_en) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win[i] <= win[i+1];
      win[WIN_LEN-1] <= rx_byte;
    end
  end

  assign frame_match = (win[0] == HEAD_BYTE) && (win[WIN_LEN-1] == TAIL_BYTE);

  // channel stream is little-endian, LSB first, starting at byte 1
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) frame_bits[i*BYTE_W +: BYTE_W] = win[i+1];
  end

endmodule

// ----- design/sfd_divider.sv -----
// ----------------------------------------------------------------------------
// sfd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfd_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sfd_pkg::DVD_W-1:0]   dividend,
  input  logic [sfd_pkg::CH_W-1:0]    divisor,
  output logic [sfd_pkg::DVD_W-1:0]   quotient,
  output logic [sfd_pkg::CH_W-1:0]    remainder,
  output sfd_pkg::div_stat_t          stat
);
  import sfd_pkg::*;

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [DVD_W-1:0]  quo;
  logic [CH_W-1:0]   rem;
  logic [CH_W:0]     trial;
  logic [CH_W:0]     diff;
  logic              fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? diff[CH_W-1:0] : trial[CH_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/sbus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS 16-channel frame decoder with normalized channel outputs.
// ----------------------------------------------------------------------------
// Each received byte shifts into a 25-byte window; a byte that does not
// complete a frame passes through accept and delimiter check before the
// next one is taken. When the oldest byte is 0x0F and the newest 0x00, the
// sixteen 11-bit channels are decoded one at a time and each is normalized
// to signed Q3.12 (floored, saturated, zero for an empty range) by one
// shared restoring divider that produces one quotient bit per cycle. A
// frame-completing byte occupies the block until every channel is out;
// in_ready stays low until the last channel is taken.
module sbus_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfd_pkg::CH_W-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sfd_pkg::CHIDX_W-1:0]     channel_index,
  output logic [sfd_pkg::CH_W-1:0]        raw_value,
  output logic signed [sfd_pkg::NORM_W-1:0] normalized,
  output logic                            last_channel
);
  import sfd_pkg::*;

  state_t state, state_next;

  logic [CH_W-1:0]    endpoint_min;
  logic [CH_W-1:0]    endpoint_max;
  logic               range_ok;
  logic [CH_W-1:0]    range_span;

  logic               frame_match;
  logic [FRAME_W-1:0] frame_bits;
  logic [FRAME_W-1:0] frame;
  logic [CHIDX_W-1:0] chan;
  logic [CH_W-1:0]    raw;
  logic               neg;

  logic [CH_W:0]      diff;
  logic [CH_W:0]      mag;
  logic [DVD_W-1:0]   dividend;
  logic [DVD_W-1:0]   quotient;
  logic [CH_W-1:0]    remainder;
  div_stat_t          div_stat;
  logic               div_start;
  logic [DVD_W:0]     ceil_mag;
  logic [NORM_W-1:0]  norm_val;

  logic               accept_in;
  logic               accept_out;
  logic               load_frame;
  logic               load_chan;
  logic               load_out;
  logic               next_chan;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      endpoint_min <= MIN_RESET;
      endpoint_max <= MAX_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_ENDPOINT_MIN) endpoint_min <= cfg_data;
      else if (cfg_index == REG_ENDPOINT_MAX) endpoint_max <= cfg_data;
    end
  end

  assign range_ok   = endpoint_max > endpoint_min;
  assign range_span = endpoint_max - endpoint_min;

  assign accept_in  = in_valid && in_ready;
  assign accept_out = out_valid && out_ready;

  sfd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (accept_in),
    .rx_byte     (rx_byte),
    .frame_match (frame_match),
    .frame_bits  (frame_bits)
  );

  // signed offset from min; divide the magnitude, fix up the sign after
  assign diff     = {1'b0, frame[CH_W-1:0]} - {1'b0, endpoint_min};
  assign mag      = diff[CH_W] ? ((CH_W+1)'(0) - diff) : diff;
  assign dividend = {mag[CH_W-1:0], {FRAC_W{1'b0}}};
  assign div_start = load_chan;

  sfd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (range_span),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // floor of a negative quotient is minus the ceiling of its magnitude
  assign ceil_mag = {1'b0, quotient} + {{DVD_W{1'b0}}, (remainder != '0)};

  always_comb begin
    if (!range_ok) begin
      norm_val = '0;
    end else if (!neg) begin
      norm_val = (quotient[DVD_W-1:NORM_W-1] != '0) ? NORM_POS_SAT
                                                   : quotient[NORM_W-1:0];
    end else if (ceil_mag > {{(DVD_W+1-NORM_W){1'b0}}, NORM_NEG_SAT}) begin
      norm_val = NORM_NEG_SAT;
    end else begin
      norm_val = NORM_W'(0) - ceil_mag[NORM_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_frame = 1'b0;
    load_chan  = 1'b0;
    load_out   = 1'b0;
    next_chan  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (frame_match) begin
          load_frame = 1'b1;
          state_next = ST_START;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_START: begin
        load_chan  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          load_out   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          next_chan  = 1'b1;
          state_next = (chan == LAST_CH) ? ST_IDLE : ST_START;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_frame)     chan <= '0;
      else if (next_chan) chan <= chan + 1'b1;
      if (load_out)        out_valid <= 1'b1;
      else if (accept_out) out_valid <= 1'b0;
    end
  end

  // channel stream shifts down one channel per transaction
  always_ff @(posedge clk) begin
    if (load_frame)     frame <= frame_bits;
    else if (next_chan) frame <= {{CH_W{1'b0}}, frame[FRAME_W-1:CH_W]};
    if (load_chan) begin
      raw <= frame[CH_W-1:0];
      neg <= diff[CH_W];
    end
    if (load_out) begin
      channel_index <= chan;
      raw_value     <= raw;
      normalized    <= norm_val;
      last_channel  <= (chan == LAST_CH);
    end
  end

`ifndef SYNTHESIS
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid && !div_stat.busy)
    else $error("input accepted while a frame is in progress");

  a_last_is_fifteen: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_channel |-> channel_index == LAST_CH)
    else $error("last channel flag on wrong channel");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept_out && last_channel |=> in_ready)
    else $error("not ready after last channel of frame");
`endif

endmodule

// ----- tb/sbus_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb
// Self-checking bench for the SBUS frame decoder. Bytes are pushed through
// the input handshake while a local copy of the 25-byte window decodes every
// matching frame into sixteen expected channel results (raw value and floored,
// saturated Q3.12 scaling). Each output transaction is checked in order
// against those. Directed frames cover the defaults, both saturation rails,
// empty ranges, overlapping frames and writes outside the register map. A
// random phase follows: mostly well-formed frames, some broken frames and
// stray bytes, random endpoint changes and random stalls on both sides.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 30;
  localparam int Q_MAX         = 32767;
  localparam int Q_MIN         = -32768;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  typedef struct {
    logic [CHIDX_W-1:0]       index;
    logic [CH_W-1:0]          raw;
    logic signed [NORM_W-1:0] norm;
    logic                     last;
  } channel_t;

  typedef enum {FILL_RANDOM, FILL_EXTREMES, FILL_SPLIT} fill_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CH_W-1:0]          cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [BYTE_W-1:0]        rx_byte   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CHIDX_W-1:0]       channel_index;
  logic [CH_W-1:0]          raw_value;
  logic signed [NORM_W-1:0] normalized;
  logic                     last_channel;

  // local copy of the decoder state
  logic [BYTE_W-1:0] rx_window [WIN_LEN];
  logic [CH_W-1:0]   lo_endpoint;
  logic [CH_W-1:0]   hi_endpoint;
  channel_t          pending_channels [$];

  logic [BYTE_W-1:0] frame_data [FRAME_BYTES];
  bit                steady_mode  = 1'b0;
  int                error_count  = 0;
  int                stall_cycles = 0;
  int                bytes_sent   = 0;

  sbus_frame_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .raw_value     (raw_value),
    .normalized    (normalized),
    .last_channel  (last_channel)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic signed [NORM_W-1:0] scale_to_q312(input logic [CH_W-1:0] raw);
    int lo, hi, span, num, q;
    lo = int'(lo_endpoint);
    hi = int'(hi_endpoint);
    if (hi <= lo) return '0;
    span = hi - lo;
    num  = (int'(raw) - lo) * (1 << FRAC_W);
    // floor toward minus infinity on the negative side
    if (num >= 0) q = num / span;
    else q = -((span - num - 1) / span);
    if (q > Q_MAX) q = Q_MAX;
    else if (q < Q_MIN) q = Q_MIN;
    return q[NORM_W-1:0];
  endfunction

  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [FRAME_W-1:0] stream;
    channel_t           c;
    for (int i = 0; i < WIN_LEN - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[WIN_LEN - 1] = b;
    if (rx_window[0] == HEAD_BYTE && rx_window[WIN_LEN - 1] == TAIL_BYTE) begin
      for (int i = 0; i < FRAME_BYTES; i++) stream[i * BYTE_W +: BYTE_W] = rx_window[i + 1];
      for (int k = 0; k < NUM_CH; k++) begin
        c.index = CHIDX_W'(k);
        c.raw   = stream[k * CH_W +: CH_W];
        c.norm  = scale_to_q312(c.raw);
        c.last  = (c.index == LAST_CH);
        pending_channels.push_back(c);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // called and returns at a falling edge; valid stays up for a following byte
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] flags,
                            input logic [BYTE_W-1:0] tail);
    send_byte(head);
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_data[i]);
    send_byte(flags);
    send_byte(tail);
  endtask

  task automatic fill_frame(input fill_t mode);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      case (mode)
        FILL_EXTREMES: frame_data[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        FILL_SPLIT:    frame_data[i] = (i < FRAME_BYTES / 2) ? 8'h00 : 8'hFF;
        default:       frame_data[i] = 8'($urandom_range(255));
      endcase
    end
  endtask

  // wait until every channel is out and the block is back to idle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_channels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == REG_ENDPOINT_MIN) lo_endpoint = value;
    else if (idx == REG_ENDPOINT_MAX) hi_endpoint = value;
  endtask

  task automatic set_range(input logic [CH_W-1:0] lo, input logic [CH_W-1:0] hi);
    write_reg(REG_ENDPOINT_MIN, lo);
    write_reg(REG_ENDPOINT_MAX, hi);
  endtask

  task automatic random_range();
    logic [CH_W-1:0] a, b;
    a = CH_W'($urandom_range(2047));
    b = CH_W'($urandom_range(2047));
    case ($urandom_range(9))
      0: begin
        a = '0;
        b = '1;
      end
      1: ; // left unordered, may be an empty range
      default: if (a > b) {a, b} = {b, a};
    endcase
    set_range(a, b);
  endtask

  task automatic test_default_range();
    // reset endpoints, channels 0-7 at zero and 8-15 at full scale
    fill_frame(FILL_SPLIT);
    send_frame(HEAD_BYTE, 8'hFF, TAIL_BYTE);
  endtask

  task automatic test_no_frame();
    send_byte(HEAD_BYTE);
    send_byte(8'hFF);
    send_byte(TAIL_BYTE);
    send_byte(8'h5A);
    send_byte(8'hA5);
  endtask

  task automatic test_saturation();
    drain_block();
    set_range(11'd0, 11'd1);
    // must not land on either endpoint register
    write_reg(REG_UNMAPPED_HI, 11'h7FF);
    write_reg(REG_UNMAPPED_LO, 11'h400);
    fill_frame(FILL_SPLIT);
    // header again one byte in, so one extra zero closes an overlapping frame
    frame_data[0] = HEAD_BYTE;
    send_frame(HEAD_BYTE, 8'h00, TAIL_BYTE);
    send_byte(TAIL_BYTE);
    drain_block();
    set_range(11'd2046, 11'd2047);
    fill_frame(FILL_SPLIT);
    send_frame(HEAD_BYTE, 8'h3C, TAIL_BYTE);
  endtask

  task automatic test_empty_range();
    drain_block();
    set_range(11'd1024, 11'd1024);
    fill_frame(FILL_RANDOM);
    send_frame(HEAD_BYTE, 8'h00, TAIL_BYTE);
    drain_block();
    set_range(11'd2047, 11'd0);
    fill_frame(FILL_EXTREMES);
    send_frame(HEAD_BYTE, 8'hFF, TAIL_BYTE);
  endtask

  task automatic test_back_to_back();
    drain_block();
    set_range(11'd0, 11'd2047);
    steady_mode = 1'b1;
    repeat (3) begin
      fill_frame(FILL_RANDOM);
      send_frame(HEAD_BYTE, 8'($urandom_range(255)), TAIL_BYTE);
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int pick, first;
    first = bytes_sent;
    drain_block();
    random_range();
    while (bytes_sent - first < RANDOM_ITEMS) begin
      steady_mode = (bytes_sent - first >= 150 && bytes_sent - first < 250);
      pick = $urandom_range(99);
      if (pick < 65) begin
        fill_frame(($urandom_range(4) == 0) ? FILL_EXTREMES : FILL_RANDOM);
        send_frame(HEAD_BYTE, 8'($urandom_range(255)), TAIL_BYTE);
        if ($urandom_range(9) < 2) begin
          // hold off until the decoder has emptied, sometimes retune the range
          drain_block();
          if ($urandom_range(1)) random_range();
        end
      end else if (pick < 85) begin
        fill_frame(FILL_RANDOM);
        if ($urandom_range(1)) send_frame(HEAD_BYTE, 8'($urandom_range(255)),
                                          8'($urandom_range(255, 1)));
        else send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), TAIL_BYTE);
      end else begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    steady_mode = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && (steady_mode || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    channel_t want;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (!rst && out_valid && out_ready) begin
      if (pending_channels.size() == 0) begin
        report_mismatch($sformatf("channel %0d with no frame pending", channel_index));
      end else begin
        want = pending_channels.pop_front();
        if (channel_index !== want.index)
          report_mismatch($sformatf("channel_index %0d, want %0d", channel_index, want.index));
        if (raw_value !== want.raw)
          report_mismatch($sformatf("ch %0d raw_value %0d, want %0d",
                                    want.index, raw_value, want.raw));
        if (normalized !== want.norm)
          report_mismatch($sformatf("ch %0d normalized %0d, want %0d",
                                    want.index, normalized, want.norm));
        if (last_channel !== want.last)
          report_mismatch($sformatf("ch %0d last_channel %0b, want %0b",
                                    want.index, last_channel, want.last));
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    foreach (rx_window[i]) rx_window[i] = WIN_RESET;
    lo_endpoint = MIN_RESET;
    hi_endpoint = MAX_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_range();
    test_no_frame();
    test_saturation();
    test_empty_range();
    test_back_to_back();
    test_random_traffic();
    drain_block();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
